@@ src/metf_pkg.sv @@
// ----------------------------------------------------------------------------
// metf_pkg
// Shared types, constants and helpers for the median/EMA tilt filter.
// ----------------------------------------------------------------------------
package metf_pkg;

  localparam int WINDOW_MAX  = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int SLOT_BITS   = $clog2(WINDOW_MAX);
  localparam int COUNT_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int WSIZE_BITS  = 4;
  localparam int ALPHA_BITS  = 17;
  localparam int CFG_BITS    = 17;
  localparam int FRAC_BITS   = 16;

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = ALPHA_BITS'(65536);
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(13107);
  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(5);

  // register indexes on the configuration port
  localparam logic CFG_WINDOW_SIZE = 1'b0;
  localparam logic CFG_ALPHA       = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t pitch_sample;
    sample_t roll_sample;
  } in_word_t;

  typedef struct packed {
    sample_t filtered_pitch;
    sample_t filtered_roll;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic search;
    logic mult;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic search_last;
    logic out_stall;
  } dp_status_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // negate for the frame change; the most negative sample clips to the maximum
  function automatic sample_t neg_sat(input sample_t x);
    sample_t r;
    if (x == SAMPLE_MIN) begin
      r = SAMPLE_MAX;
    end else begin
      r = -x;
    end
    return r;
  endfunction

endpackage

@@ src/metf_ctrl.sv @@
// ----------------------------------------------------------------------------
// metf_ctrl
// Sequencer: load a word, run the rank search, multiply, update the output.
// ----------------------------------------------------------------------------
module metf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  metf_pkg::dp_status_t status,
  output metf_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_MULT   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        // keep the input closed while reset is held
        if (!rst) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.search_last) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the output register is free
        if (!status.out_stall) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/metf_datapath.sv @@
// ----------------------------------------------------------------------------
// metf_datapath
// Sample rings, rank search, smoothing multiply and the output register.
// ----------------------------------------------------------------------------
module metf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  metf_pkg::dp_cmd_t                   cmd,
  output metf_pkg::dp_status_t                status,
  input  metf_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output metf_pkg::out_word_t                 out_data,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [metf_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int SB   = metf_pkg::SAMPLE_BITS;
  localparam int PB   = metf_pkg::ALPHA_BITS + 1 + SB + 1;
  localparam int STB  = PB - metf_pkg::FRAC_BITS;
  localparam int SUMB = STB + 1;

  metf_pkg::sample_t pitch_hist [metf_pkg::WINDOW_MAX];
  metf_pkg::sample_t roll_hist  [metf_pkg::WINDOW_MAX];

  logic [metf_pkg::SLOT_BITS-1:0]  write_slot;
  logic [metf_pkg::COUNT_BITS-1:0] fill_count;
  logic [metf_pkg::COUNT_BITS-1:0] win_n;
  logic [metf_pkg::SLOT_BITS-1:0]  cand;
  logic [metf_pkg::WSIZE_BITS-1:0] window_size;
  logic [metf_pkg::ALPHA_BITS-1:0] alpha;

  metf_pkg::sample_t med_p;
  metf_pkg::sample_t med_r;
  metf_pkg::sample_t avg_p;
  metf_pkg::sample_t avg_r;
  logic signed [PB-1:0] prod_p;
  logic signed [PB-1:0] prod_r;

  logic [metf_pkg::COUNT_BITS-1:0] fill_next;
  logic [metf_pkg::COUNT_BITS-1:0] w_eff;
  logic [metf_pkg::ALPHA_BITS-1:0] alpha_eff;
  logic [metf_pkg::WINDOW_MAX-1:0] in_win;
  logic [metf_pkg::WINDOW_MAX-1:0] less_p;
  logic [metf_pkg::WINDOW_MAX-1:0] less_r;
  logic [metf_pkg::SLOT_BITS-1:0]  age;
  logic [metf_pkg::COUNT_BITS-1:0] rank_p;
  logic [metf_pkg::COUNT_BITS-1:0] rank_r;
  logic [metf_pkg::COUNT_BITS-1:0] half;
  metf_pkg::sample_t cand_p;
  metf_pkg::sample_t cand_r;
  logic signed [SB:0]     diff_p;
  logic signed [SB:0]     diff_r;
  logic signed [SUMB-1:0] sum_p;
  logic signed [SUMB-1:0] sum_r;
  metf_pkg::sample_t avg_p_next;
  metf_pkg::sample_t avg_r_next;

  function automatic metf_pkg::sample_t sat_sum(input logic signed [SUMB-1:0] v);
    metf_pkg::sample_t r;
    if (v > $signed({{(SUMB-SB){1'b0}}, metf_pkg::SAMPLE_MAX})) begin
      r = metf_pkg::SAMPLE_MAX;
    end else if (v < $signed({{(SUMB-SB){1'b1}}, metf_pkg::SAMPLE_MIN})) begin
      r = metf_pkg::SAMPLE_MIN;
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  // ring bookkeeping and clamped configuration
  always_comb begin
    if (fill_count == metf_pkg::COUNT_BITS'(metf_pkg::WINDOW_MAX)) begin
      fill_next = fill_count;
    end else begin
      fill_next = fill_count + 1'b1;
    end
    if (window_size == '0) begin
      w_eff = metf_pkg::COUNT_BITS'(1);
    end else if ({1'b0, window_size} > (metf_pkg::WSIZE_BITS + 1)'(metf_pkg::WINDOW_MAX)) begin
      w_eff = metf_pkg::COUNT_BITS'(metf_pkg::WINDOW_MAX);
    end else begin
      w_eff = metf_pkg::COUNT_BITS'(window_size);
    end
    if (alpha > metf_pkg::ALPHA_ONE) begin
      alpha_eff = metf_pkg::ALPHA_ONE;
    end else begin
      alpha_eff = alpha;
    end
  end

  // rank of the candidate slot among the newest win_n slots, ties broken by slot
  always_comb begin
    cand_p = pitch_hist[cand];
    cand_r = roll_hist[cand];
    half   = win_n >> 1;
    age    = '0;
    for (int j = 0; j < metf_pkg::WINDOW_MAX; j++) begin
      age       = write_slot - metf_pkg::SLOT_BITS'(j) - 1'b1;
      in_win[j] = {1'b0, age} < win_n;
      less_p[j] = in_win[j] && ((pitch_hist[j] < cand_p) ||
                  ((pitch_hist[j] == cand_p) && (metf_pkg::SLOT_BITS'(j) < cand)));
      less_r[j] = in_win[j] && ((roll_hist[j] < cand_r) ||
                  ((roll_hist[j] == cand_r) && (metf_pkg::SLOT_BITS'(j) < cand)));
    end
    rank_p = metf_pkg::COUNT_BITS'($countones(less_p));
    rank_r = metf_pkg::COUNT_BITS'($countones(less_r));
  end

  // smoothing arithmetic; the arithmetic shift floors the product
  always_comb begin
    diff_p     = {med_p[SB-1], med_p} - {avg_p[SB-1], avg_p};
    diff_r     = {med_r[SB-1], med_r} - {avg_r[SB-1], avg_r};
    sum_p      = {{(SUMB-SB){avg_p[SB-1]}}, avg_p} + SUMB'(prod_p >>> metf_pkg::FRAC_BITS);
    sum_r      = {{(SUMB-SB){avg_r[SB-1]}}, avg_r} + SUMB'(prod_r >>> metf_pkg::FRAC_BITS);
    avg_p_next = sat_sum(sum_p);
    avg_r_next = sat_sum(sum_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pitch_hist[write_slot] <= metf_pkg::neg_sat(in_data.pitch_sample);
      roll_hist[write_slot]  <= metf_pkg::neg_sat(in_data.roll_sample);
    end
    if (cmd.search && in_win[cand] && (rank_p == half)) begin
      med_p <= cand_p;
    end
    if (cmd.search && in_win[cand] && (rank_r == half)) begin
      med_r <= cand_r;
    end
    if (cmd.mult) begin
      prod_p <= $signed({1'b0, alpha_eff}) * diff_p;
      prod_r <= $signed({1'b0, alpha_eff}) * diff_r;
    end
    if (cmd.update) begin
      out_data.filtered_pitch <= avg_p_next;
      out_data.filtered_roll  <= avg_r_next;
    end
    if (cmd.load) begin
      // win_n uses the count after this word is stored
      win_n <= (fill_next < w_eff) ? fill_next : w_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      fill_count  <= '0;
      cand        <= '0;
      avg_p       <= '0;
      avg_r       <= '0;
      out_valid   <= 1'b0;
      window_size <= metf_pkg::WSIZE_RESET;
      alpha       <= metf_pkg::ALPHA_RESET;
    end else begin
      if (cmd.load) begin
        write_slot <= write_slot + 1'b1;
        fill_count <= fill_next;
        cand       <= '0;
      end else if (cmd.search) begin
        cand <= cand + 1'b1;
      end
      if (cmd.update) begin
        avg_p     <= avg_p_next;
        avg_r     <= avg_r_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          metf_pkg::CFG_WINDOW_SIZE: window_size <= cfg_data[metf_pkg::WSIZE_BITS-1:0];
          metf_pkg::CFG_ALPHA:       alpha       <= cfg_data[metf_pkg::ALPHA_BITS-1:0];
          default:                   alpha       <= alpha;
        endcase
      end
    end
  end

  assign status.search_last = (cand == metf_pkg::SLOT_BITS'(metf_pkg::WINDOW_MAX - 1));
  assign status.out_stall   = out_valid && !out_ready;

endmodule

@@ src/median_then_ema_tilt_filter_core.sv @@
// ----------------------------------------------------------------------------
// median_then_ema_tilt_filter_core
// Tilt filter top level: sliding median per angle, then exponential smoothing.
// ----------------------------------------------------------------------------
// Each accepted word (pitch, roll) is negated, stored in an eight-slot ring per
// angle, reduced to the upper median of the newest window_size samples and
// blended into a running average with weight alpha (Q1.16). An accepted word
// is stored, then the rank search runs (one candidate ring slot per cycle, both
// angles side by side), then the alpha multiply, then the update step writes
// the average and output register. in_ready stays low until the update step is
// done, so the input takes no new word while one is in flight; a result waiting
// in the output register delays the update step until it is taken.
// Write window_size and alpha only while idle.
module median_then_ema_tilt_filter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  metf_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output metf_pkg::out_word_t           out_data,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [metf_pkg::CFG_BITS-1:0] cfg_data
);

  metf_pkg::dp_cmd_t    cmd;
  metf_pkg::dp_status_t status;

  metf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  metf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ src/metf_checker.sv @@
// ----------------------------------------------------------------------------
// metf_checker
// Port-level checks on the tilt filter, bound to the top level.
// ----------------------------------------------------------------------------
module metf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input metf_pkg::out_word_t           out_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready again one cycle after a word was taken");

  // the rank search keeps the input closed for the whole word
  a_busy_span: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##10 !in_ready)
    else $error("input reopened before the word finished");

endmodule

bind median_then_ema_tilt_filter_core metf_checker u_metf_checker (.*);

@@ bench/median_then_ema_tilt_filter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median_then_ema_tilt_filter_core_tb
// Self-checking bench for the median/EMA tilt filter core.
// ----------------------------------------------------------------------------
// Drives angle words through the valid/ready input with random gaps and takes
// results with random stalls. A tracker predicts every smoothed word from its
// own ring windows and running averages and checks each result in order.
// Window size and alpha are reprogrammed between phases while the core is
// idle, covering zero, clamped, lowered and extreme settings.
// ----------------------------------------------------------------------------
module median_then_ema_tilt_filter_core_tb;

  typedef metf_pkg::sample_t angle_ring_t [metf_pkg::WINDOW_MAX];

  class tilt_filter_tracker;
    angle_ring_t                       pitch_ring;
    angle_ring_t                       roll_ring;
    int                                fill_count;
    int                                write_slot;
    metf_pkg::sample_t                 pitch_avg;
    metf_pkg::sample_t                 roll_avg;
    logic [metf_pkg::WSIZE_BITS-1:0]   window_size;
    logic [metf_pkg::ALPHA_BITS-1:0]   alpha;
    metf_pkg::out_word_t               expected_angles[$];
    int                                mismatch_count;
    int                                sample_count;
    int                                checked_count;

    function new();
      fill_count     = 0;
      write_slot     = 0;
      pitch_avg      = '0;
      roll_avg       = '0;
      window_size    = metf_pkg::WSIZE_RESET;
      alpha          = metf_pkg::ALPHA_RESET;
      mismatch_count = 0;
      sample_count   = 0;
      checked_count  = 0;
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction

    task report_mismatch(string what);
      if (mismatch_count < 50) $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
    endtask

    // frame change; the most negative angle clips to the largest positive one
    function metf_pkg::sample_t flip_sign(metf_pkg::sample_t x);
      return (x == metf_pkg::SAMPLE_MIN) ? metf_pkg::SAMPLE_MAX : metf_pkg::sample_t'(-x);
    endfunction

    function metf_pkg::sample_t ring_median(angle_ring_t ring, int n);
      metf_pkg::sample_t sorted [metf_pkg::WINDOW_MAX];
      metf_pkg::sample_t v;
      int                idx;
      int                j;
      for (int i = 0; i < n; i++) begin
        idx = (write_slot + metf_pkg::WINDOW_MAX - 1 - i) % metf_pkg::WINDOW_MAX;
        v   = ring[idx];
        j   = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[n/2];
    endfunction

    // arithmetic shift gives the floor of the Q1.16 product
    function metf_pkg::sample_t blend(metf_pkg::sample_t avg, metf_pkg::sample_t med,
                                      longint weight);
      longint prod;
      longint next;
      prod = weight * (longint'(med) - longint'(avg));
      next = longint'(avg) + (prod >>> metf_pkg::FRAC_BITS);
      if (next > longint'(metf_pkg::SAMPLE_MAX)) next = longint'(metf_pkg::SAMPLE_MAX);
      if (next < longint'(metf_pkg::SAMPLE_MIN)) next = longint'(metf_pkg::SAMPLE_MIN);
      return metf_pkg::sample_t'(next);
    endfunction

    function void note_sample(metf_pkg::in_word_t w);
      int                  span;
      int                  n;
      longint              weight;
      metf_pkg::out_word_t e;
      pitch_ring[write_slot] = flip_sign(w.pitch_sample);
      roll_ring[write_slot]  = flip_sign(w.roll_sample);
      write_slot = (write_slot + 1) % metf_pkg::WINDOW_MAX;
      if (fill_count < metf_pkg::WINDOW_MAX) fill_count++;
      if (window_size == 0) span = 1;
      else if (window_size > metf_pkg::WINDOW_MAX) span = metf_pkg::WINDOW_MAX;
      else span = int'(window_size);
      n = (fill_count < span) ? fill_count : span;
      weight = (alpha > metf_pkg::ALPHA_ONE) ? longint'(metf_pkg::ALPHA_ONE) : longint'(alpha);
      pitch_avg = blend(pitch_avg, ring_median(pitch_ring, n), weight);
      roll_avg  = blend(roll_avg, ring_median(roll_ring, n), weight);
      e.filtered_pitch = pitch_avg;
      e.filtered_roll  = roll_avg;
      expected_angles = {expected_angles, e};
      sample_count++;
    endfunction

    task check_smoothed(metf_pkg::out_word_t got);
      metf_pkg::out_word_t e;
      if (expected_angles.size() == 0) begin
        report_mismatch($sformatf("unexpected result pitch %0d roll %0d",
                                  got.filtered_pitch, got.filtered_roll));
      end else begin
        e = expected_angles[0];
        expected_angles.delete(0);
        checked_count++;
        if (got.filtered_pitch !== e.filtered_pitch)
          report_mismatch($sformatf("word %0d filtered_pitch %0d, want %0d",
                                    checked_count, got.filtered_pitch, e.filtered_pitch));
        if (got.filtered_roll !== e.filtered_roll)
          report_mismatch($sformatf("word %0d filtered_roll %0d, want %0d",
                                    checked_count, got.filtered_roll, e.filtered_roll));
      end
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  metf_pkg::in_word_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  metf_pkg::out_word_t           out_data;
  logic                          cfg_write = 1'b0;
  logic                          cfg_index = metf_pkg::CFG_WINDOW_SIZE;
  logic [metf_pkg::CFG_BITS-1:0] cfg_data = '0;

  tilt_filter_tracker tracker = new();
  bit                 no_idle = 1'b0;
  int                 settings_used = 0;

  median_then_ema_tilt_filter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offer one word; valid stays high into the next word when no gap is drawn
  task automatic push_angles(metf_pkg::sample_t pitch, metf_pkg::sample_t roll);
    metf_pkg::in_word_t w;
    int                 gap;
    w.pitch_sample = pitch;
    w.roll_sample  = roll;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    tracker.note_sample(w);
  endtask

  // hold the input until every result is back, then let the core go quiet
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic program_filter(logic [metf_pkg::WSIZE_BITS-1:0] wsize,
                                logic [metf_pkg::ALPHA_BITS-1:0] weight);
    cfg_write <= 1'b1;
    cfg_index <= metf_pkg::CFG_WINDOW_SIZE;
    cfg_data  <= metf_pkg::CFG_BITS'(wsize);
    @(posedge clk);
    tracker.window_size = wsize;
    cfg_index <= metf_pkg::CFG_ALPHA;
    cfg_data  <= metf_pkg::CFG_BITS'(weight);
    @(posedge clk);
    tracker.alpha = weight;
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic metf_pkg::sample_t pick_angle(metf_pkg::sample_t prev, bit drift);
    int step;
    step = $urandom_range(0, 512);
    case ($urandom_range(0, 9))
      0:       pick_angle = metf_pkg::SAMPLE_MIN;
      1:       pick_angle = metf_pkg::SAMPLE_MAX;
      default: pick_angle = drift ? metf_pkg::sample_t'(prev + metf_pkg::sample_t'(step - 256))
                                  : metf_pkg::sample_t'($urandom);
    endcase
  endfunction

  // result side: random stalls, ready held high across back-to-back words
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_smoothed(out_data);
    end
  end

  initial begin
    logic [metf_pkg::WSIZE_BITS-1:0] wsize;
    logic [metf_pkg::ALPHA_BITS-1:0] weight;
    metf_pkg::sample_t               pitch;
    metf_pkg::sample_t               roll;
    bit                              drift;
    int                              items;
    int                              hold_at;
    int                              wait_cycles;

    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: fill the window from empty, extremes of both angles
    push_angles(metf_pkg::SAMPLE_MIN, metf_pkg::SAMPLE_MAX);
    push_angles(metf_pkg::SAMPLE_MAX, metf_pkg::SAMPLE_MIN);
    push_angles(16'sd0, 16'sd0);
    push_angles(-16'sd1, 16'sd1);
    push_angles(16'sd1, -16'sd1);
    push_angles(metf_pkg::SAMPLE_MIN, metf_pkg::SAMPLE_MIN);
    push_angles(16'sd16384, -16'sd16384);
    drain_results();

    // alpha of one and a single-sample window: output follows the negated input
    program_filter(4'd1, metf_pkg::ALPHA_ONE);
    push_angles(metf_pkg::SAMPLE_MIN, metf_pkg::SAMPLE_MAX);
    push_angles(metf_pkg::SAMPLE_MAX, metf_pkg::SAMPLE_MIN);
    push_angles(16'sd100, -16'sd100);
    drain_results();

    // both registers above range: clamp to a full window and to one
    program_filter(4'd15, {metf_pkg::ALPHA_BITS{1'b1}});
    push_angles(16'sh5555, -16'sh5556);
    push_angles(-16'sh2AAB, 16'sh2AAA);
    push_angles(metf_pkg::SAMPLE_MAX, metf_pkg::SAMPLE_MAX);
    push_angles(metf_pkg::SAMPLE_MIN, 16'sd7);
    drain_results();

    // zero window acts as one; zero alpha freezes the averages
    program_filter(4'd0, '0);
    push_angles(metf_pkg::SAMPLE_MAX, metf_pkg::SAMPLE_MIN);
    push_angles(16'sd300, 16'sd300);
    push_angles(-16'sd300, -16'sd300);
    drain_results();

    program_filter(4'd8, metf_pkg::ALPHA_BITS'(65535));
    push_angles(16'sd1000, -16'sd1000);
    push_angles(-16'sd2000, 16'sd2000);
    push_angles(16'sd3000, 16'sd50);
    push_angles(metf_pkg::SAMPLE_MIN, metf_pkg::SAMPLE_MAX);
    drain_results();

    // shrink the window with a full history behind it
    program_filter(4'd2, metf_pkg::ALPHA_BITS'(1));
    push_angles(16'sd12, -16'sd12);
    push_angles(-16'sd40, 16'sd40);
    push_angles(16'sd5, 16'sd5);
    drain_results();

    pitch = '0;
    roll  = '0;
    for (int phase = 0; phase < 12; phase++) begin
      if ($urandom_range(0, 1) == 0) wsize = metf_pkg::WSIZE_BITS'($urandom_range(1, 8));
      else wsize = metf_pkg::WSIZE_BITS'($urandom_range(0, 15));
      case ($urandom_range(0, 5))
        0:       weight = '0;
        1:       weight = metf_pkg::ALPHA_ONE;
        2:       weight = {metf_pkg::ALPHA_BITS{1'b1}};
        3:       weight = metf_pkg::ALPHA_BITS'($urandom_range(65537, 131071));
        default: weight = metf_pkg::ALPHA_BITS'($urandom_range(1, 65535));
      endcase
      program_filter(wsize, weight);
      no_idle = ($urandom_range(0, 3) == 0);
      drift   = $urandom_range(0, 1);
      items   = $urandom_range(70, 86);
      hold_at = $urandom_range(5, items - 5);
      for (int k = 0; k < items; k++) begin
        pitch = pick_angle(pitch, drift);
        roll  = pick_angle(roll, drift);
        push_angles(pitch, roll);
        if (k == hold_at) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (tracker.pending() != 0);
        end
      end
      drain_results();
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (tracker.pending() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0) begin
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
      tracker.mismatch_count += tracker.pending() - 1;
    end

    $display("Sent %0d angle words over %0d filter settings, checked %0d results.",
             tracker.sample_count, settings_used, tracker.checked_count);
    $display("Covered clamped and zero windows, alpha from zero to above one, %0d mismatches.",
             tracker.mismatch_count);
    if (tracker.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: the core stopped moving words");
    $display("Some tests failed");
    $finish;
  end

endmodule
